@@ rtl/core/fflt_pkg.sv @@
// shared types and constants of the loadable-tap fir filter
package fflt_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int COEF_W     = 18;
    localparam int COUNT_W    = 8;
    localparam int INDEX_W    = 7;
    localparam int PROD_W     = SAMPLE_W + COEF_W;
    localparam int FRAC_BITS  = 17;
    localparam int ROUND_HALF = 1 << (FRAC_BITS - 1);
    localparam int OUT_MAX    = 32767;
    localparam int OUT_MIN    = -32768;
    localparam int TAP_RESET  = 3;

    localparam logic MODE_LOAD   = 1'b0;
    localparam logic MODE_SAMPLE = 1'b1;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [COEF_W-1:0]   t_coef;
    typedef logic signed [PROD_W-1:0]   t_prod;
    typedef logic [COUNT_W-1:0]         t_count;
    typedef logic [INDEX_W-1:0]         t_index;

endpackage

@@ rtl/core/fflt_ram.sv @@
// generic single-write single-read ram with registered read data
module fflt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/core/fir_filter_loadable_taps.sv @@
// top level of the direct-form fir filter with loadable taps
//
// input channel (i_in_valid / o_in_stall): each transaction is either a
// coefficient load (i_mode 0: i_coef_index, i_coef_value) or a sample
// (i_mode 1: i_sample). a load is written in the transaction's cycle and
// gives no result; loads may follow each other every cycle while idle.
// a sample gives one transaction on the output channel (o_out_valid /
// i_out_stall, o_filtered). the block walks the taps with one
// multiply-accumulate per cycle, reading the history ram and the coefficient
// ram once per tap for min(tap count, MAX_TAPS) taps; the products pass the
// product and accumulator registers, and no new item is taken until the
// result has been written to the output register.
// o_in_stall is high while a sample is being summed. a finished result waits
// in the output register while the receiver stalls; the next sample is still
// taken, and its result waits until the register is free.
// the configuration channel writes the tap count (reset 3); o_cfg_ready is
// always high and writes belong in idle periods.
// reset (synchronous, i_rst_n low) clears the history to zero by way of a
// fill count, sets the write slot to zero and drops any pending result.
// coefficients are undefined until loaded.
module fir_filter_loadable_taps
    import fflt_pkg::*;
#(
    parameter int MAX_TAPS = 128
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  logic          i_mode,
    input  t_index        i_coef_index,
    input  t_coef         i_coef_value,
    input  t_sample       i_sample,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output t_sample       o_filtered,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  t_count        i_cfg_data
);

    localparam int AW    = $clog2(MAX_TAPS);
    localparam int CW    = $clog2(MAX_TAPS + 1);
    localparam int ACC_W = PROD_W + CW + 1;
    localparam int SH_W  = ACC_W - FRAC_BITS;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    localparam logic signed [SH_W-1:0] SAT_MAX = SH_W'(OUT_MAX);
    localparam logic signed [SH_W-1:0] SAT_MIN = SH_W'(OUT_MIN);

    logic [1:0]              r_state, n_state;
    t_count                  r_tap_count;
    logic [AW-1:0]           r_head, n_head;
    logic [AW-1:0]           r_pos, n_pos;
    logic [CW-1:0]           r_fill, n_fill;
    logic [CW-1:0]           r_taps, n_taps;
    logic [CW-1:0]           r_tap, n_tap;
    logic                    r_s1_vld, n_s1_vld;
    logic                    r_s1_zero, n_s1_zero;
    logic                    r_s2_vld;
    t_prod                   r_prod;
    logic signed [ACC_W-1:0] r_acc, n_acc;
    logic                    r_out_vld, n_out_vld;
    t_sample                 r_out, n_out;

    logic                    in_take, out_take, sample_take, load_take, issue;
    logic                    idx_ok;
    logic [8:0]              taps_lim;
    logic [SAMPLE_W-1:0]     hist_rd;
    logic [COEF_W-1:0]       coef_rd;
    t_coef                   coef_mul;
    logic signed [ACC_W-1:0] acc_rnd;
    logic signed [SH_W-1:0]  acc_sh;

    assign in_take     = i_in_valid && !o_in_stall;
    assign out_take    = r_out_vld && !i_out_stall;
    assign sample_take = in_take && (i_mode == MODE_SAMPLE);
    assign load_take   = in_take && (i_mode == MODE_LOAD) && idx_ok;
    assign idx_ok      = (9'(i_coef_index) < 9'(MAX_TAPS));
    assign issue       = (r_state == ST_RUN) && (r_tap != r_taps);
    assign taps_lim    = (9'(r_tap_count) > 9'(MAX_TAPS)) ? 9'(MAX_TAPS) : 9'(r_tap_count);

    fflt_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_TAPS)) u_hist_ram (
        .i_clk     (i_clk),
        .i_wr_en   (sample_take),
        .i_wr_addr (r_head),
        .i_wr_data (i_sample),
        .i_rd_en   (issue),
        .i_rd_addr (r_pos),
        .o_rd_data (hist_rd)
    );

    fflt_ram #(.WIDTH(COEF_W), .DEPTH(MAX_TAPS)) u_coef_ram (
        .i_clk     (i_clk),
        .i_wr_en   (load_take),
        .i_wr_addr (AW'(i_coef_index)),
        .i_wr_data (i_coef_value),
        .i_rd_en   (issue),
        .i_rd_addr (r_tap[AW-1:0]),
        .o_rd_data (coef_rd)
    );

    assign coef_mul = $signed(coef_rd);
    assign acc_rnd  = r_acc + ACC_W'(ROUND_HALF);
    assign acc_sh   = acc_rnd[ACC_W-1:FRAC_BITS];

    always_comb begin
        n_state   = r_state;
        n_head    = r_head;
        n_pos     = r_pos;
        n_fill    = r_fill;
        n_taps    = r_taps;
        n_tap     = r_tap;
        n_acc     = r_acc;
        n_s1_vld  = issue;
        n_s1_zero = (r_tap >= r_fill);
        n_out_vld = r_out_vld && !out_take;
        n_out     = r_out;
        if (r_s2_vld) begin
            n_acc = r_acc + ACC_W'(r_prod);
        end
        unique case (r_state)
            ST_IDLE: begin
                if (sample_take) begin
                    n_state = ST_RUN;
                    n_pos   = r_head;
                    n_head  = (r_head == AW'(MAX_TAPS - 1)) ? '0 : r_head + 1'b1;
                    n_fill  = (r_fill == CW'(MAX_TAPS)) ? r_fill : r_fill + 1'b1;
                    n_taps  = CW'(taps_lim);
                    n_tap   = '0;
                    n_acc   = '0;
                end
            end
            ST_RUN: begin
                if (issue) begin
                    n_tap = r_tap + 1'b1;
                    n_pos = (r_pos == '0) ? AW'(MAX_TAPS - 1) : r_pos - 1'b1;
                end else begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!r_s1_vld && !r_s2_vld && (!r_out_vld || out_take)) begin
                    n_state   = ST_IDLE;
                    n_out_vld = 1'b1;
                    if (acc_sh > SAT_MAX) begin
                        n_out = t_sample'(OUT_MAX);
                    end else if (acc_sh < SAT_MIN) begin
                        n_out = t_sample'(OUT_MIN);
                    end else begin
                        n_out = acc_sh[SAMPLE_W-1:0];
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_tap_count <= t_count'(TAP_RESET);
            r_head      <= '0;
            r_fill      <= '0;
            r_s1_vld    <= 1'b0;
            r_s2_vld    <= 1'b0;
            r_out_vld   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_head    <= n_head;
            r_fill    <= n_fill;
            r_s1_vld  <= n_s1_vld;
            r_s2_vld  <= r_s1_vld;
            r_out_vld <= n_out_vld;
            if (i_cfg_valid && o_cfg_ready) begin
                r_tap_count <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos     <= n_pos;
        r_taps    <= n_taps;
        r_tap     <= n_tap;
        r_acc     <= n_acc;
        r_s1_zero <= n_s1_zero;
        r_prod    <= r_s1_zero ? t_prod'(0) : $signed(hist_rd) * coef_mul;
        r_out     <= n_out;
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_filtered  = r_out;
    assign o_cfg_ready = 1'b1;

    // tap walk never passes the captured tap count
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN) |-> (r_tap <= r_taps))
        else $error("tap counter beyond tap count");

    // history fill count saturates at the delay line depth
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CW'(MAX_TAPS))
        else $error("fill count beyond depth");

    // products in flight only while a sample is being summed
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld || r_s2_vld) |-> (r_state == ST_RUN || r_state == ST_FIN))
        else $error("pipeline active while idle");

    // a pending result is not overwritten before it is taken
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && i_out_stall) |=> (r_out_vld && $stable(r_out)))
        else $error("stalled result lost");

    // a sample transaction always leaves the idle state
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sample_take |=> (r_state == ST_RUN))
        else $error("sample not started");

endmodule
